// ----- hw/rtl/prc_pkg.sv -----
// Package for the point/rectangle collision checker.
// Shared widths, opcodes and the per-cell result struct; no dependencies.
package prc_pkg;
  localparam int CoordW        = 24;
  localparam int DefMaxObst    = 16;
  localparam int HitW          = 4;
  localparam logic signed [CoordW-1:0] BoundLowRst  = 24'sd0;
  localparam logic signed [CoordW-1:0] BoundHighRst = 24'sd25600;

  // Configuration register indexes.
  localparam logic RegBoundLow  = 1'b0;
  localparam logic RegBoundHigh = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
  } obst_t;

  // Word carried down the cell chain during a query.
  typedef struct packed {
    logic                     busy;
    logic                     hit;
    logic [HitW-1:0]          hit_idx;
    logic signed [CoordW-1:0] mx;
    logic signed [CoordW-1:0] my;
  } qword_t;
endpackage

// ----- hw/rtl/prc_cell.sv -----
// One obstacle cell: holds one rectangle, tests the passing query point.
// Depends on prc_pkg. Two-stage compare: products, then sums and compares.
module prc_cell import prc_pkg::*; #(
  parameter int IdxW = 4,
  parameter logic [IdxW-1:0] MyIdx = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  obst_t           wr_obst,
  input  logic            valid_ent,
  input  qword_t          q_in,
  output qword_t          q_out
);
  localparam int DW = CoordW + 1;
  localparam int PW = 2 * DW;

  obst_t ob_r;
  always_ff @(posedge clk) begin
    if (wr_en) ob_r <= wr_obst;
  end

  logic signed [DW-1:0] abx, aby, adx, ady, amx, amy;
  assign abx = DW'(ob_r.bx) - DW'(ob_r.ax);
  assign aby = DW'(ob_r.by) - DW'(ob_r.ay);
  assign adx = DW'(ob_r.dx) - DW'(ob_r.ax);
  assign ady = DW'(ob_r.dy) - DW'(ob_r.ay);
  assign amx = DW'(q_in.mx) - DW'(ob_r.ax);
  assign amy = DW'(q_in.my) - DW'(ob_r.ay);

  // Stage 1: eight products, registered.
  logic signed [PW-1:0] p_r [8];
  qword_t q1_r;
  logic   v1_r;
  always_ff @(posedge clk) begin
    p_r[0] <= abx * abx;  p_r[1] <= aby * aby;
    p_r[2] <= adx * adx;  p_r[3] <= ady * ady;
    p_r[4] <= amx * abx;  p_r[5] <= amy * aby;
    p_r[6] <= amx * adx;  p_r[7] <= amy * ady;
    v1_r   <= valid_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q1_r <= '0;
    else        q1_r <= q_in;
  end

  // Stage 2: sums and strict compares; first hit wins.
  logic signed [PW:0] ab_ab, ad_ad, am_ab, am_ad;
  logic in_rect;
  assign ab_ab = (PW+1)'(p_r[0]) + (PW+1)'(p_r[1]);
  assign ad_ad = (PW+1)'(p_r[2]) + (PW+1)'(p_r[3]);
  assign am_ab = (PW+1)'(p_r[4]) + (PW+1)'(p_r[5]);
  assign am_ad = (PW+1)'(p_r[6]) + (PW+1)'(p_r[7]);
  assign in_rect = v1_r && (am_ab > 0) && (am_ab < ab_ab) &&
                   (am_ad > 0) && (am_ad < ad_ad);

  qword_t q_out_r, q_out_nxt;
  always_comb begin
    q_out_nxt = q1_r;
    if (q1_r.busy && !q1_r.hit && in_rect) begin
      q_out_nxt.hit     = 1'b1;
      q_out_nxt.hit_idx = HitW'(MyIdx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_out_r <= '0;
    else        q_out_r <= q_out_nxt;
  end

  assign q_out = q_out_r;
endmodule

// ----- hw/rtl/point_rectangle_collision_check.sv -----
// Top level of the point/rectangle collision checker.
// Depends on prc_pkg and prc_cell (a chain of MAX_OBSTACLES cells).
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall  | opcode, point, corners A B D
//   out_    | output    | out_valid/out_stall| query flags, hit_index, drop flag
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// Clear and append results are registered on accept; a query walks the point
// down the cell chain, through each cell's product and result registers.
// One word is worked on at a time; the next word is taken once the output
// register is empty or its word is read out in the same cycle.
// Reset (synchronous, rst_n low) empties the table and restores the boundary.
// Stored rectangles need no reset; only entries below the count are tested.
module point_rectangle_collision_check import prc_pkg::*; #(
  parameter int MAX_OBSTACLES = DefMaxObst
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic signed [CoordW-1:0] in_point_x,
  input  logic signed [CoordW-1:0] in_point_y,
  input  logic signed [CoordW-1:0] in_corner_a_x,
  input  logic signed [CoordW-1:0] in_corner_a_y,
  input  logic signed [CoordW-1:0] in_corner_b_x,
  input  logic signed [CoordW-1:0] in_corner_b_y,
  input  logic signed [CoordW-1:0] in_corner_d_x,
  input  logic signed [CoordW-1:0] in_corner_d_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_is_query_result,
  output logic                     out_outside_all,
  output logic                     out_inside_bounds,
  output logic [HitW-1:0]          out_hit_index,
  output logic                     out_append_dropped,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CoordW-1:0]        cfg_data
);
  localparam int IdxW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CntW = $clog2(MAX_OBSTACLES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_OBSTACLES);

  // Boundary registers.
  logic signed [CoordW-1:0] bnd_low_r, bnd_high_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_low_r  <= BoundLowRst;
      bnd_high_r <= BoundHighRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegBoundLow:  bnd_low_r  <= cfg_data;
        RegBoundHigh: bnd_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: one-hot, idle or walking a query down the chain.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;
  state_t state_r, state_nxt;

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  logic            in_acc, out_free;
  op_t             op;

  assign op       = op_t'(in_opcode);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Chain wiring: q[0] feeds cell 0, q[MAX_OBSTACLES] leaves the end.
  qword_t q [MAX_OBSTACLES+1];
  logic   wr_ok;
  assign wr_ok = in_acc && (op == OP_APPEND) && (count_r != CntMax);

  obst_t new_obst;
  assign new_obst = '{ax: in_corner_a_x, ay: in_corner_a_y,
                      bx: in_corner_b_x, by: in_corner_b_y,
                      dx: in_corner_d_x, dy: in_corner_d_y};

  assign q[0] = '{busy: in_acc && (op == OP_QUERY), hit: 1'b0, hit_idx: '0,
                  mx: in_point_x, my: in_point_y};

  for (genvar g = 0; g < MAX_OBSTACLES; g++) begin : g_cell
    prc_cell #(.IdxW(IdxW), .MyIdx(IdxW'(g))) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_ok && (count_r[IdxW-1:0] == IdxW'(g))),
      .wr_obst   (new_obst),
      .valid_ent (count_r > CntW'(g)),
      .q_in      (q[g]),
      .q_out     (q[g+1])
    );
  end

  // Hold the query's bounds verdict while the point walks.
  logic bounds_r;
  always_ff @(posedge clk) begin
    if (in_acc && op == OP_QUERY)
      bounds_r <= (in_point_x >= bnd_low_r) && (in_point_y >= bnd_low_r) &&
                  (in_point_x <= bnd_high_r) && (in_point_y <= bnd_high_r);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_CLEAR:  count_nxt = '0;
            OP_APPEND: if (wr_ok) count_nxt = count_r + 1'b1;
            OP_QUERY:  state_nxt = ST_WALK;
            default:   ;
          endcase
        end
      end
      ST_WALK: if (q[MAX_OBSTACLES].busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      // Load on a non-query word or at the end of the walk; drop when taken.
      if ((in_acc && op != OP_QUERY) || q[MAX_OBSTACLES].busy)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (in_acc && op != OP_QUERY) begin
      out_is_query_result <= 1'b0;
      out_outside_all     <= 1'b0;
      out_inside_bounds   <= 1'b0;
      out_hit_index       <= '0;
      out_append_dropped  <= (op == OP_APPEND) && (count_r == CntMax);
    end else if (q[MAX_OBSTACLES].busy) begin
      out_is_query_result <= 1'b1;
      out_outside_all     <= !q[MAX_OBSTACLES].hit;
      out_inside_bounds   <= bounds_r;
      out_hit_index       <= q[MAX_OBSTACLES].hit_idx;
      out_append_dropped  <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ----- hw/rtl/prc_checker.sv -----
// Port-level checker for the collision checker, with its bind.
// Depends on prc_pkg; sees only top-level ports.
module prc_checker import prc_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            out_is_query_result,
  input logic            out_outside_all,
  input logic            out_inside_bounds,
  input logic [HitW-1:0] out_hit_index,
  input logic            out_append_dropped
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_index))
    else $error("stalled result word changed");

  a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_query_result |->
      !out_append_dropped && (!out_outside_all || out_hit_index == '0))
    else $error("query result flags a dropped append or a stray hit index");

  a_nonquery_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_query_result |->
      !out_outside_all && !out_inside_bounds && out_hit_index == '0)
    else $error("non-query result carries query fields");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !(in_valid && !in_stall))
    else $error("input word taken while a result waits");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind point_rectangle_collision_check prc_checker u_prc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_is_query_result (out_is_query_result),
  .out_outside_all     (out_outside_all),
  .out_inside_bounds   (out_inside_bounds),
  .out_hit_index       (out_hit_index),
  .out_append_dropped  (out_append_dropped)
);

// ----- test/tb_point_rectangle_collision_check.sv -----
// Testbench for point_rectangle_collision_check: obstacle table, point queries, boundary flag.
// Depends on prc_pkg and the RTL; self-checking against a built-in behavioral predictor.
module tb_point_rectangle_collision_check;
  import prc_pkg::*;

  localparam int NumObst = DefMaxObst;
  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 4 * NumObst + 10;

  typedef struct packed {
    logic [1:0] op;
    logic signed [CoordW-1:0] px, py, ax, ay, bx, by, dx, dy;
  } cmd_t;

  typedef struct packed {
    logic is_q, outside, inb;
    logic [HitW-1:0] hit;
    logic dropped;
  } verdict_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_opcode;
  logic signed [CoordW-1:0] in_point_x, in_point_y, in_corner_a_x, in_corner_a_y;
  logic signed [CoordW-1:0] in_corner_b_x, in_corner_b_y, in_corner_d_x, in_corner_d_y;
  logic out_is_query_result, out_outside_all, out_inside_bounds, out_append_dropped;
  logic [HitW-1:0] out_hit_index;
  logic cfg_we, cfg_index;
  logic [CoordW-1:0] cfg_data;

  point_rectangle_collision_check uut (.*);

  // Predictor state: shadow table and boundary registers.
  logic signed [CoordW-1:0] bnd_low, bnd_high;
  int obst_cnt;
  obst_t table_shadow [NumObst];

  cmd_t pending_words[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit word_taken = 0;
  bit hold_long = 0;
  int hold_count = 0;
  int gap_left = 0;
  int burst_left = 0;

  function automatic logic contains(obst_t o, logic signed [CoordW-1:0] mx,
                                    logic signed [CoordW-1:0] my);
    logic signed [63:0] abx, aby, adx, ady, amx, amy, abab, adad, amab, amad;
    abx = o.bx - o.ax; aby = o.by - o.ay;
    adx = o.dx - o.ax; ady = o.dy - o.ay;
    amx = mx - o.ax;   amy = my - o.ay;
    abab = abx * abx + aby * aby;
    adad = adx * adx + ady * ady;
    amab = amx * abx + amy * aby;
    amad = amx * adx + amy * ady;
    return (amab > 0) && (amab < abab) && (amad > 0) && (amad < adad);
  endfunction

  // Advance the shadow table by one word and return the verdict it earns.
  function automatic verdict_t collision_verdict(cmd_t c);
    verdict_t v;
    obst_t o;
    v = '0;
    case (op_t'(c.op))
      OP_CLEAR: obst_cnt = 0;
      OP_APPEND: begin
        if (obst_cnt >= NumObst) v.dropped = 1'b1;
        else begin
          o.ax = c.ax; o.ay = c.ay; o.bx = c.bx; o.by = c.by; o.dx = c.dx; o.dy = c.dy;
          table_shadow[obst_cnt] = o;
          obst_cnt++;
        end
      end
      OP_QUERY: begin
        v.is_q = 1'b1;
        v.outside = 1'b1;
        for (int i = 0; i < obst_cnt; i++) begin
          if (contains(table_shadow[i], c.px, c.py)) begin
            v.outside = 1'b0;
            v.hit = i[HitW-1:0];
            break;
          end
        end
        v.inb = c.px >= bnd_low && c.py >= bnd_low && c.px <= bnd_high && c.py <= bnd_high;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [CoordW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return CoordW'($urandom);                          // full range
      1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return CoordW'($signed($urandom_range(0, 30000)) - 2000);
    endcase
  endfunction

  function automatic cmd_t rnd_word(bit noise);
    cmd_t c;
    int w, h;
    c.px = rnd_coord(); c.py = rnd_coord();
    c.ax = rnd_coord(); c.ay = rnd_coord();
    // Build a real rectangle most of the time: axis-aligned, or a tilted square.
    w = $urandom_range(0, 8000); h = $urandom_range(0, 8000);
    if (!noise && $urandom_range(0, 1)) begin
      c.bx = CoordW'(c.ax + w); c.by = CoordW'(c.ay + h);
      c.dx = CoordW'(c.ax - h); c.dy = CoordW'(c.ay + w);
    end else if (!noise) begin
      c.bx = CoordW'(c.ax + w); c.by = c.ay; c.dx = c.ax; c.dy = CoordW'(c.ay + h);
    end else begin
      c.bx = rnd_coord(); c.by = rnd_coord(); c.dx = rnd_coord(); c.dy = rnd_coord();
    end
    if (noise) c.op = 2'($urandom_range(0, 3));
    else case ($urandom_range(0, 19))
      0: c.op = OP_CLEAR;
      1, 2, 3, 4, 5: c.op = OP_APPEND;
      default: c.op = OP_QUERY;
    endcase
    return c;
  endfunction

  function automatic cmd_t mk(logic [1:0] op, int px, int py, int ax, int ay,
                              int bx, int by, int dx, int dy);
    cmd_t c;
    c.op = op; c.px = CoordW'(px); c.py = CoordW'(py);
    c.ax = CoordW'(ax); c.ay = CoordW'(ay);
    c.bx = CoordW'(bx); c.by = CoordW'(by);
    c.dx = CoordW'(dx); c.dy = CoordW'(dy);
    return c;
  endfunction

  // Queue one word for the driver.
  function automatic void add_word(cmd_t c);
    pending_words = {pending_words, c};
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Driver: bursts and gaps; hold the word until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_NONE;
      {in_point_x, in_point_y, in_corner_a_x, in_corner_a_y,
       in_corner_b_x, in_corner_b_y, in_corner_d_x, in_corner_d_y} <= '0;
    end else if (in_valid && !word_taken) begin
      // hold
    end else begin
      if (in_valid) void'(pending_words.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cmd_t c;
        c = pending_words[0];
        in_valid <= 1'b1;
        {in_opcode, in_point_x, in_point_y, in_corner_a_x, in_corner_a_y,
         in_corner_b_x, in_corner_b_y, in_corner_d_x, in_corner_d_y} <= c;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_long && hold_count < 300) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 7) < 2) && ($urandom_range(0, 99) > 30);
    end
  end

  // Predict on input accept; check on output accept.
  always @(posedge clk) begin
    if (rst_n) begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_verdicts = {expected_verdicts,
          collision_verdict({in_opcode, in_point_x, in_point_y,
          in_corner_a_x, in_corner_a_y, in_corner_b_x, in_corner_b_y,
          in_corner_d_x, in_corner_d_y})};
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (out_is_query_result !== e.is_q) begin
            $error("is_query_result exp %0d got %0d", e.is_q, out_is_query_result); errors++;
          end
          if (out_outside_all !== e.outside) begin
            $error("outside_all exp %0d got %0d", e.outside, out_outside_all); errors++;
          end
          if (out_inside_bounds !== e.inb) begin
            $error("inside_bounds exp %0d got %0d", e.inb, out_inside_bounds); errors++;
          end
          if (out_hit_index !== e.hit) begin
            $error("hit_index exp %0d got %0d", e.hit, out_hit_index); errors++;
          end
          if (out_append_dropped !== e.dropped) begin
            $error("append_dropped exp %0d got %0d", e.dropped, out_append_dropped); errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: no progress for too long ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= WatchLimit) begin
      $display("tb_point_rectangle_collision_check: done, errors");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_words.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic signed [CoordW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegBoundLow) bnd_low = val; else bnd_high = val;
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) add_word(rnd_word($urandom_range(0, 9) == 0));
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = '0;
    bnd_low = BoundLowRst; bnd_high = BoundHighRst; obst_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // Directed: empty query, bounds edges, degenerate and real rectangles,
    // strict edges, full table, unused opcode, clear.
    add_word(mk(OP_QUERY, 0, 25600, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, -1, 25601, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_APPEND, 0, 0, 100, 100, 100, 100, 100, 900));
    add_word(mk(OP_APPEND, 0, 0, 0, 0, 1000, 0, 0, 1000));
    add_word(mk(OP_QUERY, 500, 500, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, 1000, 500, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, 0, 500, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, -8388608, 8388607, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_APPEND, 0, 0, -8388608, -8388608, 8388607, -8388608,
                -8388608, 8388607));
    for (int k = 0; k < 14; k++)
      add_word(mk(OP_APPEND, 0, 0, 0, 0, 10, 0, 0, 10));
    add_word(mk(OP_QUERY, 5000, 5000, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_NONE, 1, 1, 1, 1, 1, 1, 1, 1));
    add_word(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, 5000, 5000, 0, 0, 0, 0, 0, 0));
    wait_drain();

    // Long receiver hold-off while words keep coming.
    hold_long = 1;
    random_phase(200);
    wait_drain();
    hold_long = 0;

    write_reg(RegBoundLow, 24'sh800000);
    write_reg(RegBoundHigh, 24'sh7fffff);
    random_phase(500);
    wait_drain();
    write_reg(RegBoundLow, 24'sd20000);
    write_reg(RegBoundHigh, -24'sd5);
    random_phase(300);
    wait_drain();
    write_reg(RegBoundLow, -24'sd1000);
    write_reg(RegBoundHigh, 24'sd12000);
    random_phase(800);
    wait_drain();

    if (errors == 0) $display("tb_point_rectangle_collision_check: done, clean");
    else $display("tb_point_rectangle_collision_check: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/prc_pkg.sv
hw/rtl/prc_cell.sv
hw/rtl/point_rectangle_collision_check.sv
hw/rtl/prc_checker.sv
test/tb_point_rectangle_collision_check.sv
